>>> hdl/trajectory_sampler_unit_macros.svh
// ----------------------------------------------------------------------------
// trajectory sampler assertion macros
// shared property forms for the checks inside the sampler modules
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_SAMPLER_UNIT_MACROS_SVH
`define TRAJECTORY_SAMPLER_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define TSU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tsu_pkg.sv
// ----------------------------------------------------------------------------
// tsu_pkg
// types, constants and helpers shared by the trajectory sampler modules
// ----------------------------------------------------------------------------
`default_nettype none

package tsu_pkg;

  // table geometry
  localparam int MAX_POINTS = 1024;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // step register reset value, about 0.01 s in Q16.16
  localparam logic [15:0] STEP_RESET = 16'd655;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_SAMPLE   = 3'd1,
    ST_NOT_INC  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NO_TABLE = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_APPEND, S_QCHK, S_KSET, S_ENDS, S_SRD, S_SCMP, S_VRD,
    S_VCALC, S_VMUL, S_VDIV, S_VEL, S_VELW, S_ACC, S_ACCW, S_DONE
  } state_t;

  // one stored trajectory point
  typedef struct packed {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] hd;
  } point_t;

  typedef struct packed {
    logic   en;
    ptr_t   addr;
    point_t pt;
  } st_wr_t;

  typedef struct packed {
    logic en;
    ptr_t addr_a;
    ptr_t addr_b;
  } st_rd_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  // apply sign to a rounded magnitude and saturate to signed 32 bits
  function automatic logic [31:0] rnd_sat(input logic neg, input logic [63:0] q);
    logic [31:0] r;
    if (q >= 64'h0000_0000_8000_0000) begin
      r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = neg ? (32'd0 - q[31:0]) : q[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tsu_store.sv
// ----------------------------------------------------------------------------
// tsu_store
// point table memory: one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_store (
  input  wire              clk,
  input  tsu_pkg::st_wr_t  wr,
  input  tsu_pkg::st_rd_t  rd,
  output tsu_pkg::point_t  rd_a,
  output tsu_pkg::point_t  rd_b
);
  import tsu_pkg::*;

  point_t mem [MAX_POINTS];
  point_t rd_a_r;
  point_t rd_b_r;

  // write and read, read data held until the next read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.pt;
    end
    if (rd.en) begin
      rd_a_r <= mem[rd.addr_a];
      rd_b_r <= mem[rd.addr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

`default_nettype wire

>>> hdl/tsu_div.sv
// ----------------------------------------------------------------------------
// tsu_div
// shared restoring divider, round to nearest, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_div (
  input  wire               clk,
  input  wire               rst_n,
  input  tsu_pkg::div_req_t req,
  output tsu_pkg::div_rsp_t rsp
);
  import tsu_pkg::*;

  localparam int DIV_STEPS = 64;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [63:0]       quo_r, quo_nxt;
  logic [31:0]       den_r, den_nxt;
  logic [32:0]       rem_sh;
  logic [32:0]       rem_dif;
  logic              ge;

  // one shift and subtract step
  always_comb begin
    rem_sh   = {rem_r, quo_r[63]};
    rem_dif  = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (req.start) begin
      // half the divisor added up front gives round half away from zero
      quo_nxt  = req.num + {33'd0, req.den[31:1]};
      rem_nxt  = 32'd0;
      den_nxt  = req.den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_dif[31:0] : rem_sh[31:0];
      quo_nxt = {quo_r[62:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

`default_nettype wire

>>> hdl/trajectory_sampler_unit.sv
// Append: one point at a time; the point is written, then the result loaded.
// Query: up to 16 divisions plus up to three binary searches, one per sample
// time; the shared 64-step divider takes most of the query time; one item at a time.
// Reset clears the point count, the bad mark and sets the step to 655; the
// table memory is not cleared, entries above the count are never read.
// ----------------------------------------------------------------------------
// trajectory_sampler_unit
// point table with piecewise linear sampling and backward differences
// ----------------------------------------------------------------------------
`default_nettype none

`include "trajectory_sampler_unit_macros.svh"

module trajectory_sampler_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_step_interval,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_op,
  input  wire         in_first,
  input  wire  [31:0] in_time_req,
  input  wire  [31:0] in_pos_x,
  input  wire  [31:0] in_pos_y,
  input  wire  [31:0] in_pos_z,
  input  wire  [31:0] in_heading,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_ref_x,
  output logic [31:0] out_ref_y,
  output logic [31:0] out_ref_z,
  output logic [31:0] out_vel_x,
  output logic [31:0] out_vel_y,
  output logic [31:0] out_vel_z,
  output logic [31:0] out_acc_x,
  output logic [31:0] out_acc_y,
  output logic [31:0] out_acc_z,
  output logic [31:0] out_ref_heading
);
  import tsu_pkg::*;

  state_t state_r, state_nxt;

  // persistent state
  cnt_t        cnt_r;
  logic        bad_r;
  logic [31:0] last_t_r;
  logic [15:0] step_r;

  // accepted item
  logic        op_r;
  logic        first_r;
  logic [31:0] time_r;
  logic [31:0] px_r, py_r, pz_r, phd_r;
  status_t     status_r;

  // query working registers
  logic [1:0]         k_r;
  logic [1:0]         a_r;
  logic signed [33:0] qk_r;
  logic [31:0]        hh_r;
  ptr_t               lo_r, hi_r, mid_r;
  logic               clamp_r;
  logic [31:0]        span_r;
  logic               neg_r;
  logic [63:0]        mul_p_r;
  logic [31:0]        p0_r [4];
  logic [31:0]        p1_r [3];
  logic [31:0]        p2_r [3];
  logic [31:0]        vel_r [3];
  logic [31:0]        acc_r [3];

  // result register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_f_r [10];

  // sub-block links
  st_wr_t   st_wr;
  st_rd_t   st_rd;
  point_t   rd_a, rd_b;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // combinational values
  logic [15:0]        h;
  ptr_t               last_idx;
  cnt_t               cnt_eff;
  logic               app_full, app_noinc;
  logic [PTR_W:0]     mid_sum;
  ptr_t               mid_nxt;
  logic               le_lo, ge_hi, t_le_q;
  ptr_t               lo_new, hi_new;
  logic [PTR_W:0]     gap_new;
  logic [31:0]        v_lo, v_hi;
  logic [31:0]        off, span;
  logic signed [32:0] diff;
  logic               diff_neg;
  logic [32:0]        diff_abs;
  logic [31:0]        mul_a, mul_b;
  logic [31:0]        div_res;
  logic [31:0]        p0s, p1s, p2s;
  logic signed [32:0] d1;
  logic               n1;
  logic [32:0]        m1;
  logic signed [34:0] d2;
  logic               n2;
  logic [34:0]        m2;
  logic               sat2;
  logic [1:0]         last_a;
  logic               adv;
  logic               out_load;

  tsu_store u_store (
    .clk  (clk),
    .wr   (st_wr),
    .rd   (st_rd),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  tsu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // step, with a zero step acting as one
  assign h         = (step_r == 16'd0) ? 16'd1 : step_r;
  assign last_idx  = PTR_W'(cnt_r - 1'b1);
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // append checks
  assign cnt_eff   = first_r ? '0 : cnt_r;
  assign app_full  = (cnt_eff >= CNT_W'(MAX_POINTS));
  assign app_noinc = (cnt_eff != '0) && (time_r <= last_t_r);

  // binary search step
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_nxt = mid_sum[PTR_W:1];
  assign le_lo   = (qk_r <= $signed({2'b00, rd_a.t}));
  assign ge_hi   = (qk_r >= $signed({2'b00, rd_b.t}));
  assign t_le_q  = ($signed({2'b00, rd_a.t}) <= qk_r);
  assign lo_new  = t_le_q ? mid_r : lo_r;
  assign hi_new  = t_le_q ? hi_r : mid_r;
  assign gap_new = {1'b0, hi_new} - {1'b0, lo_new};

  // end points of the segment for the current axis
  always_comb begin
    case (a_r)
      2'd0:    begin v_lo = rd_a.x;  v_hi = rd_b.x;  end
      2'd1:    begin v_lo = rd_a.y;  v_hi = rd_b.y;  end
      2'd2:    begin v_lo = rd_a.z;  v_hi = rd_b.z;  end
      default: begin v_lo = rd_a.hd; v_hi = rd_b.hd; end
    endcase
  end

  // interpolation operands
  assign off      = qk_r[31:0] - rd_a.t;
  assign span     = rd_b.t - rd_a.t;
  assign diff     = $signed({v_hi[31], v_hi}) - $signed({v_lo[31], v_lo});
  assign diff_neg = diff[32];
  assign diff_abs = diff_neg ? (33'd0 - diff) : diff;

  // shared multiplier, registered
  assign mul_a = (state_r == S_QCHK) ? {16'd0, h} : off;
  assign mul_b = (state_r == S_QCHK) ? {16'd0, h} : diff_abs[31:0];

  assign div_res = rnd_sat(neg_r, div_rsp.quot);

  // backward differences for the current axis
  assign p0s  = p0_r[a_r];
  assign p1s  = p1_r[a_r];
  assign p2s  = p2_r[a_r];
  assign d1   = $signed({p0s[31], p0s}) - $signed({p1s[31], p1s});
  assign n1   = d1[32];
  assign m1   = n1 ? (33'd0 - d1) : d1;
  assign d2   = $signed({{3{p0s[31]}}, p0s})
              - $signed({{2{p1s[31]}}, p1s, 1'b0})
              + $signed({{3{p2s[31]}}, p2s});
  assign n2   = d2[34];
  assign m2   = n2 ? (35'd0 - d2) : d2;
  assign sat2 = (m2 >= {3'd0, hh_r});

  assign last_a = (k_r == 2'd0) ? 2'd3 : 2'd2;

  // sequencer: next state and strobes
  always_comb begin
    state_nxt      = state_r;
    st_wr.en       = 1'b0;
    st_wr.addr     = cnt_eff[PTR_W-1:0];
    st_wr.pt       = '{t: time_r, x: px_r, y: py_r, z: pz_r, hd: phd_r};
    st_rd.en       = 1'b0;
    st_rd.addr_a   = lo_r;
    st_rd.addr_b   = hi_r;
    div_req.start  = 1'b0;
    div_req.num    = mul_p_r;
    div_req.den    = span_r;
    adv            = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_op ? S_QCHK : S_APPEND;
        end
      end
      S_APPEND: begin
        st_wr.en  = !app_full && !app_noinc;
        state_nxt = S_DONE;
      end
      S_QCHK: begin
        state_nxt = ((cnt_r < CNT_W'(2)) || bad_r) ? S_DONE : S_KSET;
      end
      S_KSET: begin
        st_rd.en     = 1'b1;
        st_rd.addr_a = '0;
        st_rd.addr_b = last_idx;
        state_nxt    = S_ENDS;
      end
      S_ENDS: begin
        if (le_lo || ge_hi || (last_idx == PTR_W'(1))) begin
          state_nxt = S_VRD;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        st_rd.en     = 1'b1;
        st_rd.addr_a = mid_nxt;
        state_nxt    = S_SCMP;
      end
      S_SCMP: begin
        state_nxt = (gap_new > (PTR_W+1)'(1)) ? S_SRD : S_VRD;
      end
      S_VRD: begin
        st_rd.en  = 1'b1;
        state_nxt = S_VCALC;
      end
      S_VCALC: begin
        if (clamp_r) begin
          adv = 1'b1;
        end else begin
          state_nxt = S_VMUL;
        end
      end
      S_VMUL: begin
        div_req.start = 1'b1;
        state_nxt     = S_VDIV;
      end
      S_VDIV: begin
        if (div_rsp.done) begin
          adv = 1'b1;
        end
      end
      S_VEL: begin
        div_req.start = 1'b1;
        div_req.num   = {16'd0, m1[31:0], 16'd0};
        div_req.den   = {16'd0, h};
        state_nxt     = S_VELW;
      end
      S_VELW: begin
        if (div_rsp.done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (sat2) begin
          state_nxt = (a_r == 2'd2) ? S_DONE : S_VEL;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {m2[31:0], 32'd0};
          div_req.den   = hh_r;
          state_nxt     = S_ACCW;
        end
      end
      S_ACCW: begin
        if (div_rsp.done) begin
          state_nxt = (a_r == 2'd2) ? S_DONE : S_VEL;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // end of one axis value: next axis, next sample time or differences
    if (adv) begin
      if (a_r == last_a) begin
        state_nxt = (k_r == 2'd2) ? S_VEL : S_KSET;
      end else begin
        state_nxt = S_VCALC;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      bad_r       <= 1'b0;
      step_r      <= STEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        step_r <= cfg_step_interval;
      end
      if (state_r == S_APPEND) begin
        if (first_r) begin
          bad_r <= 1'b0;
        end
        if (app_full) begin
          cnt_r <= cnt_eff;
        end else if (app_noinc) begin
          bad_r <= 1'b1;
        end else begin
          cnt_r <= cnt_eff + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mul_p_r <= 64'(mul_a) * 64'(mul_b);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_r    <= in_op;
          first_r <= in_first;
          time_r  <= in_time_req;
          px_r    <= in_pos_x;
          py_r    <= in_pos_y;
          pz_r    <= in_pos_z;
          phd_r   <= in_heading;
        end
      end
      S_APPEND: begin
        if (app_full) begin
          status_r <= ST_FULL;
        end else if (app_noinc) begin
          status_r <= ST_NOT_INC;
        end else begin
          status_r <= ST_STORED;
          last_t_r <= time_r;
        end
      end
      S_QCHK: begin
        status_r <= ((cnt_r < CNT_W'(2)) || bad_r) ? ST_NO_TABLE : ST_SAMPLE;
        k_r      <= 2'd0;
        a_r      <= 2'd0;
        qk_r     <= $signed({2'b00, time_r});
      end
      S_KSET: begin
        if (k_r == 2'd0) begin
          hh_r <= mul_p_r[31:0];
        end
      end
      S_ENDS: begin
        if (le_lo) begin
          lo_r <= '0;  hi_r <= '0;  clamp_r <= 1'b1;
        end else if (ge_hi) begin
          lo_r <= last_idx;  hi_r <= last_idx;  clamp_r <= 1'b1;
        end else begin
          lo_r <= '0;  hi_r <= last_idx;  clamp_r <= 1'b0;
        end
      end
      S_SRD: begin
        mid_r <= mid_nxt;
      end
      S_SCMP: begin
        lo_r <= lo_new;
        hi_r <= hi_new;
      end
      S_VRD: begin
        a_r <= 2'd0;
      end
      S_VCALC: begin
        neg_r  <= diff_neg;
        span_r <= span;
      end
      S_VEL: begin
        neg_r <= n1;
      end
      S_VELW: begin
        if (div_rsp.done) begin
          vel_r[a_r] <= div_res;
        end
      end
      S_ACC: begin
        if (sat2) begin
          acc_r[a_r] <= n2 ? 32'h8000_0000 : 32'h7FFF_FFFF;
          a_r        <= a_r + 1'b1;
        end else begin
          neg_r <= n2;
        end
      end
      S_ACCW: begin
        if (div_rsp.done) begin
          acc_r[a_r] <= div_res;
          a_r        <= a_r + 1'b1;
        end
      end
      default: ;
    endcase
    // store one sampled value and step the axis and sample counters
    if (adv) begin
      case (k_r)
        2'd0:    p0_r[a_r] <= clamp_r ? v_lo : (v_lo + div_res);
        2'd1:    p1_r[a_r] <= clamp_r ? v_lo : (v_lo + div_res);
        default: p2_r[a_r] <= clamp_r ? v_lo : (v_lo + div_res);
      endcase
      if (a_r == last_a) begin
        a_r <= 2'd0;
        if (k_r != 2'd2) begin
          k_r  <= k_r + 1'b1;
          qk_r <= qk_r - $signed({18'd0, h});
        end
      end else begin
        a_r <= a_r + 1'b1;
      end
    end
    // result register, fields zero unless a sample
    if (out_load) begin
      out_status_r <= status_r;
      out_f_r[0]   <= (status_r == ST_SAMPLE) ? p0_r[0]  : 32'd0;
      out_f_r[1]   <= (status_r == ST_SAMPLE) ? p0_r[1]  : 32'd0;
      out_f_r[2]   <= (status_r == ST_SAMPLE) ? p0_r[2]  : 32'd0;
      out_f_r[3]   <= (status_r == ST_SAMPLE) ? vel_r[0] : 32'd0;
      out_f_r[4]   <= (status_r == ST_SAMPLE) ? vel_r[1] : 32'd0;
      out_f_r[5]   <= (status_r == ST_SAMPLE) ? vel_r[2] : 32'd0;
      out_f_r[6]   <= (status_r == ST_SAMPLE) ? acc_r[0] : 32'd0;
      out_f_r[7]   <= (status_r == ST_SAMPLE) ? acc_r[1] : 32'd0;
      out_f_r[8]   <= (status_r == ST_SAMPLE) ? acc_r[2] : 32'd0;
      out_f_r[9]   <= (status_r == ST_SAMPLE) ? p0_r[3]  : 32'd0;
    end
  end

  // result ports
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_ref_x       = out_f_r[0];
  assign out_ref_y       = out_f_r[1];
  assign out_ref_z       = out_f_r[2];
  assign out_vel_x       = out_f_r[3];
  assign out_vel_y       = out_f_r[4];
  assign out_vel_z       = out_f_r[5];
  assign out_acc_x       = out_f_r[6];
  assign out_acc_y       = out_f_r[7];
  assign out_acc_z       = out_f_r[8];
  assign out_ref_heading = out_f_r[9];

  // checks on the sequencer and the shared divider
  `TSU_ASSERT_SAME(a_ready_div_idle, in_ready, !div_rsp.busy, "divider busy while idle")
  `TSU_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_POINTS), "point count over table")
  `TSU_ASSERT_SAME(a_search_gap, state_r == S_SRD, {1'b0, hi_r} > ({1'b0, lo_r} + 1'b1), "search without gap")
  `TSU_ASSERT_NEXT(a_div_start, div_req.start, div_rsp.busy, "divider did not start")

endmodule

`default_nettype wire
